### hw/rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// Timer expiry table package
// Shared sizes, codes, transaction types and cell control for the timer table.
// ----------------------------------------------------------------------------
package tet_pkg;

  // Table geometry
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned GroupSize  = 4;
  localparam int unsigned NumGroups  = (TimerSlots + GroupSize - 1) / GroupSize;

  // Delay value that means no timer is pending
  localparam logic [47:0] NoExpiry = 48'hFFFF_FFFF_FFFF;

  // Operation codes
  localparam logic [1:0] OpRegister = 2'd0;
  localparam logic [1:0] OpPoll     = 2'd1;
  localparam logic [1:0] OpCancel   = 2'd2;

  // Status codes
  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusMiss = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  // Request transaction
  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] now_ms;
    logic [31:0] timeout_ms;
    logic [7:0]  timer_kind;
    logic [31:0] user_word;
    logic [31:0] cancel_id;
  } cmd_t;

  // Response transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_id;
    logic [7:0]  expired_kind;
    logic [31:0] expired_word;
    logic [47:0] next_expiry_ms;
  } rsp_t;

  // Contents of one timer slot
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  kind;
    logic [47:0] expiry;
    logic [31:0] word;
  } entry_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic step;    // update cycle
    logic insert;  // register: first free cell takes the new entry
    logic remove;  // poll or cancel: first hit leaves, later cells move down
    logic by_id;   // hit on id match rather than on expiry
  } cell_ctrl_t;

endpackage

### hw/rtl/tet_cell.sv
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one timer slot, finds its own hit, takes part in the priority chain,
// shifts down from its upper neighbour on removal and offers a delay candidate.
// ----------------------------------------------------------------------------
module tet_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tet_pkg::cell_ctrl_t   ctrl_i,
  input  tet_pkg::entry_t       wr_entry_i,
  input  logic [47:0]           now_i,
  input  logic [31:0]           cancel_id_i,
  input  logic                  left_valid_i,
  input  logic                  hit_before_i,
  input  logic                  next_valid_i,
  input  tet_pkg::entry_t       next_entry_i,
  output logic                  valid_o,
  output tet_pkg::entry_t       entry_o,
  output logic                  hit_o,
  output logic                  hit_before_o,
  output logic [47:0]           cand_o
);

  logic            valid_q, valid_d;
  tet_pkg::entry_t entry_q, entry_d;
  logic [47:0]     cand_q, cand_d;
  logic [48:0]     diff;
  logic            late;
  logic            match;
  logic            flag;
  logic            shift;
  logic            write;

  // Compare against the current time and the cancel id
  assign diff  = {1'b0, entry_q.expiry} - {1'b0, now_i};
  assign late  = diff[48] | (diff[47:0] == '0);
  assign match = (entry_q.id == cancel_id_i);
  assign flag  = valid_q & (ctrl_i.by_id ? match : late);

  // Priority chain: only the first flagged cell hits
  assign hit_o        = flag & ~hit_before_i;
  assign hit_before_o = hit_before_i | flag;

  // Move down from the upper neighbour at or above the hit, or take a new entry
  assign shift = ctrl_i.step & ctrl_i.remove & hit_before_o;
  assign write = ctrl_i.step & ctrl_i.insert & ~valid_q & left_valid_i;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (shift) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end else if (write) begin
      valid_d = 1'b1;
      entry_d = wr_entry_i;
    end
  end

  // Delay candidate of the surviving contents
  always_comb begin
    cand_d = tet_pkg::NoExpiry;
    if (valid_q && !(ctrl_i.remove && hit_o)) begin
      cand_d = late ? '0 : diff[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold slot contents and candidate
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.step) begin
      cand_q <= cand_d;
    end
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;
  assign cand_o  = cand_q;

endmodule

### hw/rtl/tet_min_tree.sv
// ----------------------------------------------------------------------------
// Timer table minimum tree
// Two-level minimum over the cell candidates: registered group minima, then a
// final pick across the groups.
// ----------------------------------------------------------------------------
module tet_min_tree (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [47:0] cand_i [tet_pkg::TimerSlots],
  output logic [47:0] min_o
);

  logic [47:0] grp_min_d [tet_pkg::NumGroups];
  logic [47:0] grp_min_q [tet_pkg::NumGroups];

  // Reduce each group of cells
  always_comb begin
    for (int g = 0; g < int'(tet_pkg::NumGroups); g++) begin
      grp_min_d[g] = tet_pkg::NoExpiry;
      for (int k = 0; k < int'(tet_pkg::GroupSize); k++) begin
        if (g * int'(tet_pkg::GroupSize) + k < int'(tet_pkg::TimerSlots)) begin
          if (cand_i[g * int'(tet_pkg::GroupSize) + k] < grp_min_d[g]) begin
            grp_min_d[g] = cand_i[g * int'(tet_pkg::GroupSize) + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_min_q <= grp_min_d;
    end
  end

  // Pick across the groups
  always_comb begin
    min_o = tet_pkg::NoExpiry;
    for (int g = 0; g < int'(tet_pkg::NumGroups); g++) begin
      if (grp_min_q[g] < min_o) begin
        min_o = grp_min_q[g];
      end
    end
  end

endmodule

### hw/rtl/timer_expiry_table_core.sv
// ----------------------------------------------------------------------------
// Timer expiry table core
// One-shot timer list held in a chain of cells in insertion order, with
// register, poll-for-expired and cancel operations and a cached next delay.
// ----------------------------------------------------------------------------
//
//   port group        direction  qualifier           payload
//   start / cmd_i     in         start && !busy      tet_pkg::cmd_t
//   done_o / rsp_o    out        done_o (one cycle)  tet_pkg::rsp_t
//
// Each transaction passes through accept, cell update, group minimum and final
// minimum. The response strobe is high in the cycle after the final minimum,
// which is also the first cycle a new transaction can be accepted. The steps
// after the cell update are the two-level minimum tree over the cell candidates.
// Reset clears all valid bits, the id counter and sets the next delay to
// all ones; slot contents are not cleared. The receiver cannot stall.
module timer_expiry_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tet_pkg::cmd_t  cmd_i,
  output logic           done_o,
  output tet_pkg::rsp_t  rsp_o
);

  localparam int unsigned N = tet_pkg::TimerSlots;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StExec   = 2'd1;
  localparam logic [1:0] StReduce = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]          state_q, state_d;
  tet_pkg::cmd_t       cmd_q;
  logic [31:0]         id_cnt_q, id_cnt_d;
  logic [47:0]         next_exp_q, next_exp_d;
  logic                recompute_q, recompute_d;
  logic [1:0]          status_q, status_d;
  logic [31:0]         new_id_q, new_id_d;
  logic [7:0]          ekind_q, ekind_d;
  logic [31:0]         eword_q, eword_d;
  logic                done_q;
  tet_pkg::rsp_t       rsp_q;
  logic                accept;

  tet_pkg::cell_ctrl_t ctrl;
  tet_pkg::entry_t     wr_entry;
  logic [48:0]         exp_sum;

  logic [N-1:0]        valid_vec;
  logic [N-1:0]        left_vec;
  logic [N-1:0]        before_in;
  logic [N-1:0]        before_vec;
  logic [N-1:0]        hit_vec;
  logic [N-1:0]        next_valid_in;
  tet_pkg::entry_t     entries [N];
  tet_pkg::entry_t     next_entry_in [N];
  logic [47:0]         cands [N];
  logic [47:0]         tree_min;
  logic [7:0]          hit_kind;
  logic [31:0]         hit_word;
  logic                table_full;
  logic                any_hit;

  assign accept = start & ~busy;
  assign busy   = (state_q != StIdle);

  // Broadcast control to the cells
  assign ctrl.step   = (state_q == StExec);
  assign ctrl.insert = (cmd_q.op == tet_pkg::OpRegister);
  assign ctrl.remove = (cmd_q.op == tet_pkg::OpPoll) || (cmd_q.op == tet_pkg::OpCancel);
  assign ctrl.by_id  = (cmd_q.op == tet_pkg::OpCancel);

  // Build the new entry with a saturating absolute expiry
  assign exp_sum         = {1'b0, cmd_q.now_ms} + {17'b0, cmd_q.timeout_ms};
  assign wr_entry.id     = id_cnt_q;
  assign wr_entry.kind   = cmd_q.timer_kind;
  assign wr_entry.expiry = exp_sum[48] ? tet_pkg::NoExpiry : exp_sum[47:0];
  assign wr_entry.word   = cmd_q.user_word;

  // Chain of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_vec[i]  = 1'b1;
      assign before_in[i] = 1'b0;
    end else begin : g_body
      assign left_vec[i]  = valid_vec[i-1];
      assign before_in[i] = before_vec[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign next_valid_in[i] = 1'b0;
      assign next_entry_in[i] = '0;
    end else begin : g_link
      assign next_valid_in[i] = valid_vec[i+1];
      assign next_entry_in[i] = entries[i+1];
    end

    tet_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .wr_entry_i   (wr_entry),
      .now_i        (cmd_q.now_ms),
      .cancel_id_i  (cmd_q.cancel_id),
      .left_valid_i (left_vec[i]),
      .hit_before_i (before_in[i]),
      .next_valid_i (next_valid_in[i]),
      .next_entry_i (next_entry_in[i]),
      .valid_o      (valid_vec[i]),
      .entry_o      (entries[i]),
      .hit_o        (hit_vec[i]),
      .hit_before_o (before_vec[i]),
      .cand_o       (cands[i])
    );
  end

  tet_min_tree u_min_tree (
    .clk_i  (clk_i),
    .load_i (state_q == StReduce),
    .cand_i (cands),
    .min_o  (tree_min)
  );

  assign table_full = valid_vec[N-1];
  assign any_hit    = before_vec[N-1];

  // Select the contents of the hit cell
  always_comb begin
    hit_kind = '0;
    hit_word = '0;
    for (int i = 0; i < int'(N); i++) begin
      hit_kind = hit_kind | ({8{hit_vec[i]}} & entries[i].kind);
      hit_word = hit_word | ({32{hit_vec[i]}} & entries[i].word);
    end
  end

  // Sequence the transaction and decide the outcome
  always_comb begin
    state_d     = state_q;
    id_cnt_d    = id_cnt_q;
    next_exp_d  = next_exp_q;
    recompute_d = recompute_q;
    status_d    = status_q;
    new_id_d    = new_id_q;
    ekind_d     = ekind_q;
    eword_d     = eword_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d     = StReduce;
        recompute_d = 1'b0;
        status_d    = tet_pkg::StatusMiss;
        new_id_d    = '0;
        ekind_d     = '0;
        eword_d     = '0;
        unique case (cmd_q.op)
          tet_pkg::OpRegister: begin
            if (table_full) begin
              status_d = tet_pkg::StatusFull;
            end else begin
              status_d = tet_pkg::StatusOk;
              new_id_d = id_cnt_q;
              id_cnt_d = id_cnt_q + 32'd1;
              if ({16'b0, cmd_q.timeout_ms} < next_exp_q) begin
                next_exp_d = {16'b0, cmd_q.timeout_ms};
              end
            end
          end
          tet_pkg::OpPoll: begin
            if (any_hit) begin
              status_d = tet_pkg::StatusOk;
              ekind_d  = hit_kind;
              eword_d  = hit_word;
            end else begin
              recompute_d = 1'b1;
            end
          end
          tet_pkg::OpCancel: begin
            if (any_hit) begin
              status_d    = tet_pkg::StatusOk;
              recompute_d = 1'b1;
            end
          end
          default: begin
            status_d = tet_pkg::StatusMiss;
          end
        endcase
      end
      StReduce: begin
        state_d = StFinish;
      end
      StFinish: begin
        state_d = StIdle;
        if (recompute_q) begin
          next_exp_d = tree_min;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      id_cnt_q    <= '0;
      next_exp_q  <= tet_pkg::NoExpiry;
      recompute_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      id_cnt_q    <= id_cnt_d;
      next_exp_q  <= next_exp_d;
      recompute_q <= recompute_d;
      done_q      <= (state_q == StFinish);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    status_q <= status_d;
    new_id_q <= new_id_d;
    ekind_q  <= ekind_d;
    eword_q  <= eword_d;
    if (state_q == StFinish) begin
      rsp_q.status         <= status_q;
      rsp_q.new_id         <= new_id_q;
      rsp_q.expired_kind   <= ekind_q;
      rsp_q.expired_word   <= eword_q;
      rsp_q.next_expiry_ms <= next_exp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Accepted transaction goes straight to the cell update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StExec))
    else $error("accepted transaction did not enter update");

  // Response strobe only once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == StIdle) && $past(state_q == StFinish))
    else $error("response strobe out of sequence");

  // Valid cells stay packed from the bottom of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + N'(1))) == '0)
    else $error("valid cells not packed");

  // Full status only when every cell holds a timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == tet_pkg::StatusFull)) |-> (&valid_vec))
    else $error("full status with a free cell");

endmodule

### test/tet_expiry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer expiry table checker
// Watches the command and response channels of the timer table, keeps its own
// copy of the timer list, and compares each response with the predicted one.
// ----------------------------------------------------------------------------
module tet_expiry_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  tet_pkg::cmd_t  cmd_i,
  input  logic           done_i,
  input  tet_pkg::rsp_t  rsp_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o,
  output int unsigned    checked_o
);

  localparam int Slots = int'(tet_pkg::TimerSlots);

  // Shadow timer list, packed from slot 0 in insertion order
  logic            slot_live [Slots];
  tet_pkg::entry_t slot_data [Slots];
  logic [31:0]     id_next;
  logic [47:0]     cached_delay;

  // Responses still owed by the block, oldest first
  tet_pkg::rsp_t   owed_replies [$];

  // Close the gap left by a removed timer, moving later ones down
  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < Slots; i++) begin
      slot_live[i] = slot_live[i + 1];
      slot_data[i] = slot_data[i + 1];
    end
    slot_live[Slots - 1] = 1'b0;
  endfunction

  // Rebuild the cached delay: zero if anything is late, else the nearest one
  function automatic void refresh_delay(input logic [47:0] now_ms);
    logic [47:0] best;
    logic        late;
    best = tet_pkg::NoExpiry;
    late = 1'b0;
    for (int i = 0; i < Slots; i++) begin
      if (slot_live[i]) begin
        if (slot_data[i].expiry <= now_ms) begin
          late = 1'b1;
        end else if (slot_data[i].expiry - now_ms < best) begin
          best = slot_data[i].expiry - now_ms;
        end
      end
    end
    cached_delay = late ? '0 : best;
  endfunction

  // Apply one command to the shadow list and return the response it earns
  function automatic tet_pkg::rsp_t step_timer_table(input tet_pkg::cmd_t c);
    tet_pkg::rsp_t r;
    int            hit;
    logic [48:0]   sum;
    r        = '0;
    r.status = tet_pkg::StatusMiss;
    hit      = -1;
    case (c.op)
      tet_pkg::OpRegister: begin
        for (int i = 0; i < Slots; i++) begin
          if (!slot_live[i] && hit < 0) hit = i;
        end
        if (hit < 0) begin
          r.status = tet_pkg::StatusFull;
        end else begin
          // saturate the absolute expiry at 48 bits
          sum = {1'b0, c.now_ms} + {17'h0, c.timeout_ms};
          slot_live[hit]        = 1'b1;
          slot_data[hit].id     = id_next;
          slot_data[hit].kind   = c.timer_kind;
          slot_data[hit].expiry = sum[48] ? tet_pkg::NoExpiry : sum[47:0];
          slot_data[hit].word   = c.user_word;
          r.new_id = id_next;
          id_next  = id_next + 32'd1;
          if ({16'h0, c.timeout_ms} < cached_delay) cached_delay = {16'h0, c.timeout_ms};
          r.status = tet_pkg::StatusOk;
        end
      end
      tet_pkg::OpPoll: begin
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && slot_live[i] && slot_data[i].expiry <= c.now_ms) hit = i;
        end
        if (hit >= 0) begin
          // a hit leaves the cached delay as it was
          r.expired_kind = slot_data[hit].kind;
          r.expired_word = slot_data[hit].word;
          close_gap(hit);
          r.status = tet_pkg::StatusOk;
        end else begin
          refresh_delay(c.now_ms);
        end
      end
      tet_pkg::OpCancel: begin
        for (int i = 0; i < Slots; i++) begin
          if (hit < 0 && slot_live[i] && slot_data[i].id == c.cancel_id) hit = i;
        end
        if (hit >= 0) begin
          close_gap(hit);
          refresh_delay(c.now_ms);
          r.status = tet_pkg::StatusOk;
        end
      end
      default: begin
        // unused op code: no state change
      end
    endcase
    r.next_expiry_ms = cached_delay;
    return r;
  endfunction

  // Report one field that differs; returns the number of failures
  function automatic int unsigned field_differs(input string name, input logic [47:0] want_v,
                                                input logic [47:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // Retire responses against the oldest prediction, then predict new transactions
  always @(posedge clk_i or negedge rst_ni) begin
    tet_pkg::rsp_t want;
    int unsigned   bad;
    bad = 0;
    if (!rst_ni) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      id_next      = '0;
      cached_delay = tet_pkg::NoExpiry;
      owed_replies.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (done_i) begin
        if (owed_replies.size() == 0) begin
          $error("response strobe with no transaction outstanding");
          bad = 1;
        end else begin
          want = owed_replies.pop_front();
          bad += field_differs("status", 48'(want.status), 48'(rsp_i.status));
          bad += field_differs("new_id", 48'(want.new_id), 48'(rsp_i.new_id));
          bad += field_differs("expired_kind", 48'(want.expired_kind),
                               48'(rsp_i.expired_kind));
          bad += field_differs("expired_word", 48'(want.expired_word),
                               48'(rsp_i.expired_word));
          bad += field_differs("next_expiry_ms", want.next_expiry_ms, rsp_i.next_expiry_ms);
          checked_o <= checked_o + 1;
        end
      end
      if (start_i && !busy_i) owed_replies = {owed_replies, step_timer_table(cmd_i)};
      if (bad != 0) fail_count_o <= fail_count_o + bad;
      pending_o <= owed_replies.size();
    end
  end

endmodule

### test/timer_expiry_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer expiry table core testbench
// Issues directed and random register, poll and cancel transactions under
// varying idle patterns; a checker beside the core predicts every response.
// ----------------------------------------------------------------------------
module timer_expiry_table_core_tb;

  localparam logic [1:0]  OpReserved  = 2'd3;
  localparam int unsigned ItemTarget  = 700;
  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 12;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  tet_pkg::cmd_t cmd;
  logic          done;
  tet_pkg::rsp_t rsp;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned replies_checked;
  int unsigned cycle_count = 0;
  int unsigned items_sent;
  int unsigned op_count [4];
  int unsigned idle_pct;
  logic [47:0] sim_now;
  logic [31:0] ids_issued;

  timer_expiry_table_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd),
    .done_o (done),
    .rsp_o  (rsp)
  );

  tet_expiry_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .done_i       (done),
    .rsp_i        (rsp),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (replies_checked)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: abandon a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Hold a transaction on the command port until the core takes it
  task automatic send_cmd(input tet_pkg::cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    op_count[c.op]++;
    items_sent++;
    if (c.op == tet_pkg::OpRegister) ids_issued++;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start for a random number of cycles
  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Hold off until every outstanding response has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic issue(input logic [1:0] op, input logic [47:0] now_ms,
                       input logic [31:0] timeout_ms, input logic [7:0] kind,
                       input logic [31:0] word, input logic [31:0] cid);
    tet_pkg::cmd_t c;
    c.op         = op;
    c.now_ms     = now_ms;
    c.timeout_ms = timeout_ms;
    c.timer_kind = kind;
    c.user_word  = word;
    c.cancel_id  = cid;
    idle_gap();
    send_cmd(c);
  endtask

  // Mostly short timeouts so timers expire soon, with zero and full-range ones
  function automatic logic [31:0] pick_timeout();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      default: return $urandom_range(250, 1);
    endcase
  endfunction

  // An id near the most recent ones, so cancels mostly hit
  function automatic logic [31:0] recent_id();
    return ids_issued - 32'($urandom_range(20));
  endfunction

  task automatic issue_register();
    issue(tet_pkg::OpRegister, sim_now, pick_timeout(), 8'($urandom), $urandom, $urandom);
  endtask

  // One random burst of transactions, mostly coherent with a rising clock
  task automatic random_burst();
    int unsigned mode;
    logic [63:0] wide;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      // mixed traffic
      repeat ($urandom_range(8, 1)) begin
        sim_now = sim_now + 48'($urandom_range(30));
        case ($urandom_range(9))
          0, 1, 2, 3: issue_register();
          4, 5, 6, 7: issue(tet_pkg::OpPoll, sim_now, $urandom, 8'($urandom), $urandom,
                            $urandom);
          default:    issue(tet_pkg::OpCancel, sim_now, $urandom, 8'($urandom), $urandom,
                            recent_id());
        endcase
      end
    end else if (mode <= 5) begin
      // fill the table, often past full
      repeat ($urandom_range(18, 4)) begin
        sim_now = sim_now + 48'($urandom_range(5));
        issue_register();
      end
    end else if (mode <= 7) begin
      // advance the clock, then drain expired timers
      sim_now = sim_now + 48'($urandom_range(300));
      repeat ($urandom_range(10, 2)) begin
        sim_now = sim_now + 48'($urandom_range(3));
        issue(tet_pkg::OpPoll, sim_now, $urandom, 8'($urandom), $urandom, $urandom);
      end
    end else if (mode == 8) begin
      repeat ($urandom_range(4, 1)) begin
        issue(tet_pkg::OpCancel, sim_now, $urandom, 8'($urandom), $urandom, recent_id());
      end
    end else begin
      // noise: any op, any time, any id
      repeat ($urandom_range(3, 1)) begin
        wide = {$urandom, $urandom};
        issue(2'($urandom_range(3)),
              ($urandom_range(3) == 0) ? tet_pkg::NoExpiry : wide[47:0],
              $urandom, 8'($urandom), $urandom, $urandom);
      end
    end
  endtask

  // Stimulus
  initial begin
    int unsigned phase_goal;
    logic [63:0] wide;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd         = '0;
    items_sent  = 0;
    idle_pct    = 0;
    sim_now     = '0;
    ids_issued  = '0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, reserved op, extremes of the fields
    issue(tet_pkg::OpPoll, '0, '0, '0, '0, '0);
    issue(tet_pkg::OpCancel, '0, '0, '0, '0, '1);
    issue(OpReserved, tet_pkg::NoExpiry, '1, '1, '1, '1);
    issue(tet_pkg::OpRegister, '0, '0, 8'hFF, 32'hFFFF_FFFF, '0);
    // expiry saturates at the top of the 48-bit range
    issue(tet_pkg::OpRegister, tet_pkg::NoExpiry - 48'd5, 32'hFFFF_FFFF, 8'h00, 32'h0, '0);
    issue(tet_pkg::OpRegister, 48'd100, 32'd10, 8'h5A, 32'hA5A5_A5A5, '0);
    // poll hit keeps the cached delay; poll miss recomputes it
    issue(tet_pkg::OpPoll, 48'd100, '0, '0, '0, '0);
    issue(tet_pkg::OpPoll, 48'd105, '0, '0, '0, '0);
    // cancel hit, then the same id again as a miss on a non-empty table
    issue(tet_pkg::OpCancel, 48'd105, '0, '0, '0, 32'd2);
    issue(tet_pkg::OpCancel, 48'd105, '0, '0, '0, 32'd2);
    // fill every slot, then register once more into a full table
    for (int i = 0; i < 15; i++) begin
      issue(tet_pkg::OpRegister, 48'd200, 32'(i * 7 + 1), 8'(i * 17), ~32'(i), '0);
    end
    issue(tet_pkg::OpRegister, 48'd200, 32'd3, 8'h11, 32'h1234_5678, '0);
    issue(tet_pkg::OpPoll, tet_pkg::NoExpiry, '0, '0, '0, '0);
    wait_drained();

    // Random phases: no idling, heavy idling, light idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          sim_now  = 48'($urandom_range(1000));
        end
        1: begin
          idle_pct = 73;
          wide     = {$urandom, $urandom};
          sim_now  = wide[47:0];
        end
        default: begin
          idle_pct = 28;
          sim_now  = tet_pkg::NoExpiry - 48'($urandom_range(5000));
        end
      endcase
      phase_goal = items_sent + ItemTarget / 3;
      while (items_sent < phase_goal) random_burst();
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d transactions: %0d register, %0d poll, %0d cancel, %0d unused op",
             items_sent, op_count[tet_pkg::OpRegister], op_count[tet_pkg::OpPoll],
             op_count[tet_pkg::OpCancel], op_count[OpReserved]);
    $display("Checked %0d responses across directed, idle-free and idling phases",
             replies_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### timer_expiry_table_core.f
hw/rtl/tet_pkg.sv
hw/rtl/tet_cell.sv
hw/rtl/tet_min_tree.sv
hw/rtl/timer_expiry_table_core.sv
test/tet_expiry_checker.sv
test/timer_expiry_table_core_tb.sv
